// ----- src/cemm_pkg.sv -----
// Shared types, codes and constants of the controller event to MIDI mapper.
package cemm_pkg;

  localparam int MATRIX_BUTTONS  = 16;
  localparam int SPECIAL_BUTTONS = 4;
  localparam int STOP_BUTTONS    = 4;
  localparam int FADER_COUNT     = 4;
  localparam int RAW_MAX         = 4095;
  localparam int CC_MAX          = 127;

  localparam int FUNC_W     = 3;
  localparam int INDEX_W    = 4;
  localparam int RAW_W      = 12;
  localparam int KIND_W     = 2;
  localparam int CHAN_W     = 4;
  localparam int NUM_W      = 7;
  localparam int DATA_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int SLOTS        = 24;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int SPECIAL_BASE = 16;
  localparam int STOP_BASE    = 20;
  localparam int ENC_SLOTS    = 8;
  localparam int ENC_W        = $clog2(ENC_SLOTS);
  localparam int KNOB_BASE    = 4;
  localparam int CTRL_COUNT   = 9;
  localparam int CTRL_W       = $clog2(CTRL_COUNT);
  localparam logic [CTRL_W-1:0] WHEEL_CTRL = CTRL_W'(8);

  localparam int NOTE_WORD_W = 8 * NUM_W;
  localparam int CTRL_WORD_W = CTRL_COUNT * NUM_W;
  localparam int SETUP_W     = 32;

  localparam logic [FUNC_W-1:0] FUNC_MATRIX  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SPECIAL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FADER   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_KNOB    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_WHEEL   = 3'd5;

  localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CC       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_TABLE_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_TABLE_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_TABLE_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_TABLE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_SETUP = 3'd5;

  // round(v * CC_MAX / RAW_MAX) half up = floor((2*v*CC_MAX + RAW_MAX) / (2*RAW_MAX)),
  // done as one constant multiply by a reciprocal that is exact over the whole range
  localparam longint unsigned SCALE_DIV   = 2 * RAW_MAX;
  localparam longint unsigned SCALE_NMAX  = 2 * RAW_MAX * CC_MAX + RAW_MAX;
  localparam int              SCALE_NW    = $clog2(SCALE_NMAX + 1);
  localparam int              SCALE_DW    = $clog2(SCALE_DIV + 1);
  localparam int              SCALE_SH    = SCALE_NW + SCALE_DW;
  localparam longint unsigned SCALE_RECIP =
    ((longint'(1) << SCALE_SH) + SCALE_DIV - 1) / SCALE_DIV;
  localparam longint unsigned SCALE_K1    = 2 * CC_MAX * SCALE_RECIP;
  localparam longint unsigned SCALE_K0    = RAW_MAX * SCALE_RECIP;
  localparam int              SCALE_W     = SCALE_SH + NUM_W + 1;

  typedef enum logic [1:0] {
    OP_BUTTON,
    OP_ENCODER,
    OP_WHEEL
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic               pressed;
    logic [ENC_W-1:0]   enc;
    logic               wheel_up;
    logic [NUM_W-1:0]   scaled;
  } entry_t;

  typedef struct packed {
    logic [SLOTS-1:0]                 toggle_mask;
    logic [SLOTS-1:0][NUM_W-1:0]      notes;
    logic [CTRL_COUNT-1:0][NUM_W-1:0] ctrls;
    logic [CHAN_W-1:0]                channel;
    logic [DATA_W-1:0]                vel_on;
    logic [DATA_W-1:0]                vel_off;
    logic [DATA_W-1:0]                wheel_inc;
    logic [DATA_W-1:0]                wheel_dec;
  } cfg_t;

endpackage

// ----- src/cemm_in_if.sv -----
// Panel event request channel.
interface cemm_in_if;
  logic                           valid;
  logic                           ready;
  logic [cemm_pkg::FUNC_W-1:0]    func;
  logic [cemm_pkg::INDEX_W-1:0]   index;
  logic                           pressed;
  logic [cemm_pkg::RAW_W-1:0]     raw_value;
  logic                           wheel_up;

  modport source(output valid, func, index, pressed, raw_value, wheel_up, input ready);
  modport sink(input valid, func, index, pressed, raw_value, wheel_up, output ready);
endinterface

// ----- src/cemm_out_if.sv -----
// MIDI message request channel.
interface cemm_out_if;
  logic                          valid;
  logic                          ready;
  logic [cemm_pkg::KIND_W-1:0]   msg_kind;
  logic [cemm_pkg::CHAN_W-1:0]   midi_channel;
  logic [cemm_pkg::NUM_W-1:0]    number;
  logic [cemm_pkg::DATA_W-1:0]   data_value;
  logic                          led_on;

  modport source(output valid, msg_kind, midi_channel, number, data_value, led_on,
                 input ready);
  modport sink(input valid, msg_kind, midi_channel, number, data_value, led_on,
               output ready);
endinterface

// ----- src/cemm_cfg_if.sv -----
// Configuration register write channel.
interface cemm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cemm_pkg::CFG_IDX_W-1:0]   index;
  logic [cemm_pkg::CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- src/controller_event_to_midi_mapper_unit.sv -----
// Top level of the controller event to MIDI mapper.
//
// in_ch takes one panel event per request (button, fader, knob or wheel step);
// out_ch gives at most one MIDI message per event, in event order. Events that
// make no message (unused func, index out of range, toggle release, unchanged
// position) are dropped without a slot on out_ch.
// cfg_ch writes the six mapping registers; it is always ready. The user must write
// it only while no event is in flight; the block itself does not enforce this.
// An accepted event reaches out_ch through the queue and the output register:
// the front end classifies and scales into a two-entry queue, the back end
// updates button and position state and loads the output register.
// Throughput: one event per cycle while out_ch is ready, set by the state update
// in the back end. When out_ch stalls, the output register holds its message, the
// queue fills and in_ch.ready drops once both queue entries are taken.
// Reset clears the registers, button states and stored positions to zero and
// empties the queue and the output register.
module controller_event_to_midi_mapper_unit (
  input  logic         clk,
  input  logic         rst_n,
  cemm_in_if.sink      in_ch,
  cemm_out_if.source   out_ch,
  cemm_cfg_if.sink     cfg_ch
);

  cemm_pkg::cfg_t    cfg;
  logic              q_full;
  logic              push;
  cemm_pkg::entry_t  push_entry;
  logic              head_valid;
  cemm_pkg::entry_t  head_entry;
  logic              pop;

  cemm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  cemm_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  cemm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop)
  );

  cemm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ----- src/cemm_cfg_regs.sv -----
// Configuration registers and their unpacking into mapping tables.
module cemm_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  cemm_cfg_if.sink        cfg_ch,
  output cemm_pkg::cfg_t  cfg
);

  logic [cemm_pkg::SLOTS-1:0]       toggle_r;
  logic [cemm_pkg::NOTE_WORD_W-1:0] note_a_r;
  logic [cemm_pkg::NOTE_WORD_W-1:0] note_b_r;
  logic [cemm_pkg::NOTE_WORD_W-1:0] note_c_r;
  logic [cemm_pkg::CTRL_WORD_W-1:0] ctrl_r;
  logic [cemm_pkg::SETUP_W-1:0]     setup_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_r <= '0;
      note_a_r <= '0;
      note_b_r <= '0;
      note_c_r <= '0;
      ctrl_r   <= '0;
      setup_r  <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        cemm_pkg::CFG_TOGGLE_MASK:   toggle_r <= cfg_ch.data[cemm_pkg::SLOTS-1:0];
        cemm_pkg::CFG_NOTE_TABLE_A:  note_a_r <= cfg_ch.data[cemm_pkg::NOTE_WORD_W-1:0];
        cemm_pkg::CFG_NOTE_TABLE_B:  note_b_r <= cfg_ch.data[cemm_pkg::NOTE_WORD_W-1:0];
        cemm_pkg::CFG_NOTE_TABLE_C:  note_c_r <= cfg_ch.data[cemm_pkg::NOTE_WORD_W-1:0];
        cemm_pkg::CFG_CTRL_TABLE:    ctrl_r   <= cfg_ch.data[cemm_pkg::CTRL_WORD_W-1:0];
        cemm_pkg::CFG_MESSAGE_SETUP: setup_r  <= cfg_ch.data[cemm_pkg::SETUP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.toggle_mask = toggle_r;
  assign cfg.notes       = {note_c_r, note_b_r, note_a_r};
  assign cfg.ctrls       = ctrl_r;
  assign cfg.channel     = setup_r[3:0];
  assign cfg.vel_on      = setup_r[10:4];
  assign cfg.vel_off     = setup_r[17:11];
  assign cfg.wheel_inc   = setup_r[24:18];
  assign cfg.wheel_dec   = setup_r[31:25];

endmodule

// ----- src/cemm_front.sv -----
// Front end: accepts panel events, drops invalid ones, maps slots and scales positions.
module cemm_front (
  cemm_in_if.sink                 in_ch,
  input  logic                    q_full,
  output logic                    push,
  output cemm_pkg::entry_t        push_entry
);

  logic                          keep;
  logic [cemm_pkg::RAW_W-1:0]    raw_c;
  logic [cemm_pkg::SCALE_W-1:0]  prod;
  logic [cemm_pkg::NUM_W:0]      scaled_full;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && in_ch.ready && keep;

  always_comb begin
    raw_c = (32'(in_ch.raw_value) > cemm_pkg::RAW_MAX) ?
            cemm_pkg::RAW_W'(cemm_pkg::RAW_MAX) : in_ch.raw_value;
    prod  = cemm_pkg::SCALE_W'(raw_c) * cemm_pkg::SCALE_W'(cemm_pkg::SCALE_K1) +
            cemm_pkg::SCALE_W'(cemm_pkg::SCALE_K0);
    scaled_full = prod[cemm_pkg::SCALE_W-1:cemm_pkg::SCALE_SH];
  end

  always_comb begin
    keep                = 1'b0;
    push_entry.op       = cemm_pkg::OP_WHEEL;
    push_entry.slot     = cemm_pkg::SLOT_W'(in_ch.index);
    push_entry.pressed  = in_ch.pressed;
    push_entry.enc      = cemm_pkg::ENC_W'(in_ch.index);
    push_entry.wheel_up = in_ch.wheel_up;
    push_entry.scaled   = (32'(scaled_full) > cemm_pkg::CC_MAX) ?
                          cemm_pkg::NUM_W'(cemm_pkg::CC_MAX) :
                          cemm_pkg::NUM_W'(scaled_full);
    case (in_ch.func)
      cemm_pkg::FUNC_MATRIX: begin
        keep          = 32'(in_ch.index) < cemm_pkg::MATRIX_BUTTONS;
        push_entry.op = cemm_pkg::OP_BUTTON;
      end
      cemm_pkg::FUNC_SPECIAL: begin
        keep            = 32'(in_ch.index) < cemm_pkg::SPECIAL_BUTTONS;
        push_entry.op   = cemm_pkg::OP_BUTTON;
        push_entry.slot = cemm_pkg::SLOT_W'(cemm_pkg::SPECIAL_BASE) +
                          cemm_pkg::SLOT_W'(in_ch.index);
      end
      cemm_pkg::FUNC_STOP: begin
        keep            = 32'(in_ch.index) < cemm_pkg::STOP_BUTTONS;
        push_entry.op   = cemm_pkg::OP_BUTTON;
        push_entry.slot = cemm_pkg::SLOT_W'(cemm_pkg::STOP_BASE) +
                          cemm_pkg::SLOT_W'(in_ch.index);
      end
      cemm_pkg::FUNC_FADER: begin
        keep          = 32'(in_ch.index) < cemm_pkg::FADER_COUNT;
        push_entry.op = cemm_pkg::OP_ENCODER;
      end
      cemm_pkg::FUNC_KNOB: begin
        keep           = 32'(in_ch.index) < cemm_pkg::FADER_COUNT;
        push_entry.op  = cemm_pkg::OP_ENCODER;
        push_entry.enc = cemm_pkg::ENC_W'(cemm_pkg::KNOB_BASE) +
                         cemm_pkg::ENC_W'(in_ch.index);
      end
      cemm_pkg::FUNC_WHEEL: begin
        keep          = 1'b1;
        push_entry.op = cemm_pkg::OP_WHEEL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/cemm_queue.sv -----
// Two-entry queue between the front end and the back end.
module cemm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cemm_pkg::entry_t  push_entry,
  output logic              full,
  output logic              head_valid,
  output cemm_pkg::entry_t  head_entry,
  input  logic              pop
);

  cemm_pkg::entry_t mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

// ----- src/cemm_back.sv -----
// Back end: button and position state, message build and output register.
module cemm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  cemm_pkg::cfg_t    cfg,
  input  logic              head_valid,
  input  cemm_pkg::entry_t  head_entry,
  output logic              pop,
  cemm_out_if.source        out_ch
);

  logic [cemm_pkg::SLOTS-1:0]  button_state_r;
  logic [cemm_pkg::NUM_W-1:0]  last_cc_r [cemm_pkg::ENC_SLOTS];

  logic                         out_valid_r;
  logic [cemm_pkg::KIND_W-1:0]  out_kind_r;
  logic [cemm_pkg::CHAN_W-1:0]  out_chan_r;
  logic [cemm_pkg::NUM_W-1:0]   out_num_r;
  logic [cemm_pkg::DATA_W-1:0]  out_data_r;
  logic                         out_led_r;

  logic                         has_res;
  logic                         cur_on;
  logic                         on_nxt;
  logic [cemm_pkg::KIND_W-1:0]  kind_nxt;
  logic [cemm_pkg::NUM_W-1:0]   num_nxt;
  logic [cemm_pkg::DATA_W-1:0]  data_nxt;
  logic                         led_nxt;

  assign pop = head_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    has_res  = 1'b0;
    cur_on   = button_state_r[head_entry.slot];
    on_nxt   = cur_on;
    kind_nxt = cemm_pkg::KIND_CC;
    num_nxt  = cfg.ctrls[cemm_pkg::WHEEL_CTRL];
    data_nxt = head_entry.scaled;
    led_nxt  = 1'b0;
    case (head_entry.op)
      cemm_pkg::OP_BUTTON: begin
        if (cfg.toggle_mask[head_entry.slot]) begin
          on_nxt  = !cur_on;
          has_res = head_entry.pressed;
        end else begin
          on_nxt  = head_entry.pressed;
          has_res = 1'b1;
        end
        kind_nxt = on_nxt ? cemm_pkg::KIND_NOTE_ON : cemm_pkg::KIND_NOTE_OFF;
        num_nxt  = cfg.notes[head_entry.slot];
        data_nxt = on_nxt ? cfg.vel_on : cfg.vel_off;
        led_nxt  = on_nxt;
      end
      cemm_pkg::OP_ENCODER: begin
        has_res = head_entry.scaled != last_cc_r[head_entry.enc];
        num_nxt = cfg.ctrls[cemm_pkg::CTRL_W'(head_entry.enc)];
      end
      cemm_pkg::OP_WHEEL: begin
        has_res  = 1'b1;
        data_nxt = head_entry.wheel_up ? cfg.wheel_inc : cfg.wheel_dec;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_state_r <= '0;
      for (int i = 0; i < cemm_pkg::ENC_SLOTS; i++) last_cc_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop && has_res && head_entry.op == cemm_pkg::OP_BUTTON)
        button_state_r[head_entry.slot] <= on_nxt;
      if (pop && has_res && head_entry.op == cemm_pkg::OP_ENCODER)
        last_cc_r[head_entry.enc] <= head_entry.scaled;
      if (pop && has_res)     out_valid_r <= 1'b1;
      else if (out_ch.ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_res) begin
      out_kind_r <= kind_nxt;
      out_chan_r <= cfg.channel;
      out_num_r  <= num_nxt;
      out_data_r <= data_nxt;
      out_led_r  <= led_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.msg_kind     = out_kind_r;
  assign out_ch.midi_channel = out_chan_r;
  assign out_ch.number       = out_num_r;
  assign out_ch.data_value   = out_data_r;
  assign out_ch.led_on       = out_led_r;

endmodule

// ----- verif/cemm_checker.sv -----
// Scoreboard for the event to MIDI mapper: predicts messages from accepted events and compares.
`timescale 1ns / 100ps
module cemm_checker (
  input  logic clk,
  input  logic rst_n,
  cemm_in_if   in_ch,
  cemm_out_if  out_ch,
  cemm_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  import cemm_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] chan;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] data;
    logic              led;
  } midi_msg_t;

  logic [SLOTS-1:0]       toggle_r;
  logic [NOTE_WORD_W-1:0] notes_a, notes_b, notes_c;
  logic [CTRL_WORD_W-1:0] ctrl_tbl;
  logic [SETUP_W-1:0]     setup_r;

  logic [SLOTS-1:0] lit_state;
  logic [NUM_W-1:0] sent_pos [ENC_SLOTS];

  midi_msg_t awaited_msgs [$];

  function automatic logic [NUM_W-1:0] note_of(int slot);
    if (slot < 8) return notes_a[NUM_W*slot +: NUM_W];
    if (slot < SPECIAL_BASE) return notes_b[NUM_W*(slot-8) +: NUM_W];
    return notes_c[NUM_W*(slot-SPECIAL_BASE) +: NUM_W];
  endfunction

  function automatic bit press_button(int slot, logic press, output midi_msg_t msg);
    logic lit;
    if (toggle_r[slot]) begin
      if (!press) return 0;
      lit_state[slot] = ~lit_state[slot];
    end else begin
      lit_state[slot] = press;
    end
    lit = lit_state[slot];
    msg.kind = lit ? KIND_NOTE_ON : KIND_NOTE_OFF;
    msg.chan = setup_r[3:0];
    msg.num  = note_of(slot);
    msg.data = lit ? setup_r[10:4] : setup_r[17:11];
    msg.led  = lit;
    return 1;
  endfunction

  function automatic bit move_encoder(int k, logic [RAW_W-1:0] raw, output midi_msg_t msg);
    int unsigned v, pos;
    v = (32'(raw) > RAW_MAX) ? RAW_MAX : 32'(raw);
    pos = (2 * v * CC_MAX + RAW_MAX) / (2 * RAW_MAX);
    if (pos > CC_MAX) pos = CC_MAX;
    if (pos[NUM_W-1:0] == sent_pos[k]) return 0;
    sent_pos[k] = pos[NUM_W-1:0];
    msg = '{KIND_CC, setup_r[3:0], ctrl_tbl[NUM_W*k +: NUM_W], pos[NUM_W-1:0], 1'b0};
    return 1;
  endfunction

  function automatic bit map_event(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                                   logic press, logic [RAW_W-1:0] raw, logic up,
                                   output midi_msg_t msg);
    case (func)
      FUNC_MATRIX:
        if (int'(idx) < MATRIX_BUTTONS) return press_button(int'(idx), press, msg);
      FUNC_SPECIAL:
        if (int'(idx) < SPECIAL_BUTTONS)
          return press_button(SPECIAL_BASE + int'(idx), press, msg);
      FUNC_STOP:
        if (int'(idx) < STOP_BUTTONS) return press_button(STOP_BASE + int'(idx), press, msg);
      FUNC_FADER:
        if (int'(idx) < FADER_COUNT) return move_encoder(int'(idx), raw, msg);
      FUNC_KNOB:
        if (int'(idx) < FADER_COUNT) return move_encoder(KNOB_BASE + int'(idx), raw, msg);
      FUNC_WHEEL: begin
        msg = '{KIND_CC, setup_r[3:0], ctrl_tbl[NUM_W*int'(WHEEL_CTRL) +: NUM_W],
                up ? setup_r[24:18] : setup_r[31:25], 1'b0};
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  task automatic check_field(string what, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    midi_msg_t want, got;
    if (!rst_n) begin
      toggle_r  = '0;
      notes_a   = '0;
      notes_b   = '0;
      notes_c   = '0;
      ctrl_tbl  = '0;
      setup_r   = '0;
      lit_state = '0;
      for (int k = 0; k < ENC_SLOTS; k++) sent_pos[k] = '0;
      awaited_msgs.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TOGGLE_MASK:   toggle_r = cfg_ch.data[SLOTS-1:0];
          CFG_NOTE_TABLE_A:  notes_a  = cfg_ch.data[NOTE_WORD_W-1:0];
          CFG_NOTE_TABLE_B:  notes_b  = cfg_ch.data[NOTE_WORD_W-1:0];
          CFG_NOTE_TABLE_C:  notes_c  = cfg_ch.data[NOTE_WORD_W-1:0];
          CFG_CTRL_TABLE:    ctrl_tbl = cfg_ch.data[CTRL_WORD_W-1:0];
          CFG_MESSAGE_SETUP: setup_r  = cfg_ch.data[SETUP_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (map_event(in_ch.func, in_ch.index, in_ch.pressed, in_ch.raw_value,
                      in_ch.wheel_up, want))
          awaited_msgs.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.msg_kind, out_ch.midi_channel, out_ch.number, out_ch.data_value,
                out_ch.led_on};
        if (awaited_msgs.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected message, expected none, %s %0d ch %0d num %0d data %0d led %0d",
                   $time, "got kind", got.kind, got.chan, got.num, got.data, got.led);
        end else begin
          want = awaited_msgs.pop_front();
          check_field("msg_kind", 32'(want.kind), 32'(got.kind));
          check_field("midi_channel", 32'(want.chan), 32'(got.chan));
          check_field("number", 32'(want.num), 32'(got.num));
          check_field("data_value", 32'(want.data), 32'(got.data));
          check_field("led_on", 32'(want.led), 32'(got.led));
        end
      end
    end
    pending = awaited_msgs.size();
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the event to MIDI mapper testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module testbench;
  import cemm_pkg::*;

  localparam logic [FUNC_W-1:0]    FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0]    FUNC_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;

  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_PHASES   = 4;
  localparam int PHASE_EVENTS    = 190;
  localparam int DRAIN_CYCLES    = 8;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count, pending;
  bit   squeeze_req;
  int   calm_left;

  cemm_in_if  in_ch();
  cemm_out_if out_ch();
  cemm_cfg_if cfg_ch();

  controller_event_to_midi_mapper_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cemm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_event(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx, logic press,
                            logic [RAW_W-1:0] raw, logic up);
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.index     <= idx;
    in_ch.pressed   <= press;
    in_ch.raw_value <= raw;
    in_ch.wheel_up  <= up;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // mode 0: all clear, 1: all set, otherwise a random mix per register
  task automatic load_setup(int mode);
    logic [CFG_DATA_W-1:0] word;
    int pick;
    for (int i = int'(CFG_TOGGLE_MASK); i <= int'(CFG_MESSAGE_SETUP); i++) begin
      pick = (mode < 2) ? mode : $urandom_range(0, 9);
      if (pick == 0) word = '0;
      else if (pick == 1) word = '1;
      else word = {$urandom, $urandom};
      write_reg(CFG_IDX_W'(i), word);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_event(output bit counted);
    int r;
    logic [FUNC_W-1:0]  f;
    logic [INDEX_W-1:0] ix;
    logic [RAW_W-1:0]   raw;
    r  = $urandom_range(0, 99);
    ix = INDEX_W'($urandom);
    counted = 1'b1;
    case ($urandom_range(0, 4))
      0: raw = '0;
      1: raw = '1;
      2: raw = RAW_W'($urandom_range(0, 40));
      3: raw = RAW_W'(RAW_MAX - $urandom_range(0, 40));
      default: raw = RAW_W'($urandom);
    endcase
    if (r < 30) begin
      f  = FUNC_MATRIX;
      ix = INDEX_W'($urandom_range(0, MATRIX_BUTTONS - 1));
    end else if (r < 38) begin
      f  = FUNC_SPECIAL;
      ix = INDEX_W'($urandom_range(0, SPECIAL_BUTTONS - 1));
    end else if (r < 46) begin
      f  = FUNC_STOP;
      ix = INDEX_W'($urandom_range(0, STOP_BUTTONS - 1));
    end else if (r < 62) begin
      f  = FUNC_FADER;
      ix = INDEX_W'($urandom_range(0, FADER_COUNT - 1));
    end else if (r < 78) begin
      f  = FUNC_KNOB;
      ix = INDEX_W'($urandom_range(0, FADER_COUNT - 1));
    end else if (r < 88) begin
      f = FUNC_WHEEL;
    end else if (r < 94) begin
      f = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
      counted = 1'b0;
    end else begin
      // index past the group
      f  = FUNC_W'(FUNC_SPECIAL + $urandom_range(0, 3));
      ix = INDEX_W'($urandom_range(FADER_COUNT, 15));
      counted = 1'b0;
    end
    send_event(f, ix, 1'($urandom), raw, 1'($urandom));
  endtask

  // receiver
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
      end
      out_ch.ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 150) : $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("controller_event_to_midi_mapper_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    bit counted;
    int done;
    squeeze_req     = 1'b0;
    calm_left       = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_MATRIX;
    in_ch.index     <= '0;
    in_ch.pressed   <= 1'b0;
    in_ch.raw_value <= '0;
    in_ch.wheel_up  <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_TOGGLE_MASK;
    cfg_ch.data     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // toggle mode on matrix 5, special 2 and stop 3
    write_reg(CFG_TOGGLE_MASK, 64'h0000_0000_0084_0020);
    write_reg(CFG_NOTE_TABLE_A, {$urandom, $urandom});
    write_reg(CFG_NOTE_TABLE_B, {$urandom, $urandom});
    write_reg(CFG_NOTE_TABLE_C, {$urandom, $urandom});
    write_reg(CFG_CTRL_TABLE, {$urandom, $urandom});
    write_reg(CFG_MESSAGE_SETUP, {$urandom, $urandom});
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;

    send_event(FUNC_FADER, 0, 1'b0, 12'd0, 1'b0);    // zero position: no message
    send_event(FUNC_FADER, 0, 1'b1, 12'hFFF, 1'b1);
    send_event(FUNC_FADER, 0, 1'b0, 12'hFFF, 1'b0);  // unchanged
    send_event(FUNC_FADER, 3, 1'b0, 12'd16, 1'b0);   // rounds down to zero
    send_event(FUNC_KNOB, 3, 1'b1, 12'd33, 1'b1);    // rounds up to one
    send_event(FUNC_KNOB, 0, 1'b0, 12'd2047, 1'b0);
    send_event(FUNC_FADER, 4, 1'b0, 12'd100, 1'b0);  // out of group
    send_event(FUNC_KNOB, 15, 1'b1, 12'hFFF, 1'b1);
    send_event(FUNC_MATRIX, 0, 1'b1, 12'hABC, 1'b1);
    send_event(FUNC_MATRIX, 0, 1'b0, 12'h543, 1'b0);
    send_event(FUNC_MATRIX, 15, 1'b1, 12'd0, 1'b0);
    send_event(FUNC_MATRIX, 5, 1'b1, 12'd0, 1'b0);   // toggle on
    send_event(FUNC_MATRIX, 5, 1'b0, 12'd0, 1'b0);   // toggle release: nothing
    send_event(FUNC_MATRIX, 5, 1'b1, 12'd0, 1'b0);   // toggle off
    send_event(FUNC_SPECIAL, 0, 1'b1, 12'd0, 1'b0);
    send_event(FUNC_SPECIAL, 2, 1'b1, 12'd0, 1'b0);
    send_event(FUNC_SPECIAL, 2, 1'b0, 12'd0, 1'b0);
    send_event(FUNC_SPECIAL, 4, 1'b1, 12'd0, 1'b0);  // out of group
    send_event(FUNC_STOP, 3, 1'b1, 12'hFFF, 1'b1);
    send_event(FUNC_STOP, 0, 1'b1, 12'd0, 1'b0);
    send_event(FUNC_STOP, 0, 1'b0, 12'd0, 1'b0);
    send_event(FUNC_STOP, 15, 1'b1, 12'd0, 1'b0);
    send_event(FUNC_WHEEL, 15, 1'b1, 12'hFFF, 1'b1);
    send_event(FUNC_WHEEL, 0, 1'b0, 12'd0, 1'b0);
    send_event(FUNC_SPARE_LO, 3, 1'b1, 12'hFFF, 1'b1);
    send_event(FUNC_SPARE_HI, 15, 1'b1, 12'hFFF, 1'b1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_setup((p == 1) ? 1 : (p == 2) ? 0 : 2);
      if (p % 2 == 1) squeeze_req = 1'b1;
      done = 0;
      while (done < PHASE_EVENTS) begin
        send_random_event(counted);
        if (counted) done++;
      end
      wait_idle();
    end

    if (fail_count == 0 && pending == 0)
      $display("controller_event_to_midi_mapper_unit regression: pass");
    else
      $display("controller_event_to_midi_mapper_unit regression: fail");
    $finish;
  end

endmodule
